/* rtl/dlcs_pkg.sv */
// ----------------------------------------------------------------------------
// dlcs_pkg
// Shared types and codes of the detector layer combination selector: register
// indexes, region codes, mode bit positions and the command and status structs
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dlcs_pkg;

  localparam int unsigned LAYER_W   = 12;
  localparam int unsigned SIZE_EN_W = 9;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MODE_COSMIC  = 0;
  localparam int unsigned MODE_MIX     = 1;
  localparam int unsigned MODE_SPECIAL = 2;

  typedef enum logic [1:0] {
    REG_BARREL = 2'd0,
    REG_NEG    = 2'd1,
    REG_POS    = 2'd2,
    REG_MIX    = 2'd3
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_SIZE_EN   = 2'd1,
    CFG_LAYER_SEL = 2'd2,
    CFG_REQUIRED  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              load;
    logic              init;
    logic              step;
    logic              flush;
    logic              special;
    logic              strict;
    region_t           region;
    logic [SIZE_W-1:0] size;
  } dlcs_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [SIZE_EN_W-1:0] size_enable;
    logic [SIZE_W-1:0]    region_count;
    logic                 advance;
    logic                 hit_limit;
    logic                 last_combo;
    logic                 flush_done;
  } dlcs_sts_t;

endpackage

/* rtl/dlcs_datapath.sv */
// ----------------------------------------------------------------------------
// dlcs_datapath
// Configuration registers, event hit mask, combination stepper, candidate
// filter, one-deep pending result and the output register.
// ----------------------------------------------------------------------------
module dlcs_datapath #(
  parameter int unsigned BARREL_LAYERS      = 6,
  parameter int unsigned ENDCAP_SIDE_LAYERS = 3,
  parameter int unsigned RESULT_LIMIT       = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [dlcs_pkg::LAYER_W-1:0]    hit_mask,
  input  logic                            cfg_write,
  input  logic [dlcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlcs_pkg::LAYER_W-1:0]    cfg_data,
  input  dlcs_pkg::dlcs_cmd_t             cmd,
  output dlcs_pkg::dlcs_sts_t             sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [dlcs_pkg::LAYER_W-1:0]    layer_mask,
  output logic [1:0]                      region,
  output logic                            truncated,
  output logic                            last_result
);
  import dlcs_pkg::*;

  localparam int unsigned LW = (BARREL_LAYERS > ENDCAP_SIDE_LAYERS) ?
                               BARREL_LAYERS : ENDCAP_SIDE_LAYERS;
  localparam int unsigned CW        = $clog2(LW + 1);
  localparam int unsigned CNT_W     = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned NEG_FIRST = BARREL_LAYERS;
  localparam int unsigned POS_FIRST = BARREL_LAYERS + ENDCAP_SIDE_LAYERS;
  localparam int unsigned ALL_END   = BARREL_LAYERS + 2 * ENDCAP_SIDE_LAYERS;

  function automatic logic [LW-1:0] take_local(logic [LAYER_W-1:0] v,
                                               int unsigned first, int unsigned cnt);
    logic [LW-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < LW; i++) begin
      if (i < cnt && first + i < LAYER_W) r[i] = v[first + i];
    end
    return r;
  endfunction

  function automatic logic [LAYER_W-1:0] place(logic [LW-1:0] v,
                                               int unsigned first, int unsigned cnt);
    logic [LAYER_W-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < LW; i++) begin
      if (i < cnt && first + i < LAYER_W) r[first + i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [LAYER_W-1:0] span12(int unsigned first, int unsigned cnt);
    logic [LAYER_W-1:0] r;
    r = '0;
    for (int unsigned k = 0; k < LAYER_W; k++) begin
      if (k >= first && k < first + cnt) r[k] = 1'b1;
    end
    return r;
  endfunction

  // scatter the compressed selection onto the hit positions
  function automatic logic [LW-1:0] deposit(logic [LW-1:0] c, logic [LW-1:0] h);
    logic [LW-1:0] r;
    logic [LW-1:0] t;
    r = '0;
    t = c;
    for (int unsigned i = 0; i < LW; i++) begin
      if (h[i]) begin
        r[i] = t[0];
        t    = t >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] popcount(logic [LW-1:0] h);
    logic [CW-1:0] n;
    n = '0;
    for (int unsigned i = 0; i < LW; i++) n = n + CW'(h[i]);
    return n;
  endfunction

  // next subset in lexicographic order over n compressed positions
  // msb of the result is set when a next subset exists
  function automatic logic [LW:0] next_comb(logic [LW-1:0] c, logic [CW-1:0] n);
    logic          free;
    logic          found;
    logic [CW-1:0] pos;
    logic [CW-1:0] run;
    logic [LW-1:0] r;
    free  = 1'b0;
    found = 1'b0;
    pos   = '0;
    run   = '0;
    r     = '0;
    for (int i = LW - 1; i >= 0; i--) begin
      if (CW'(i) < n && !found) begin
        if (c[i]) begin
          if (free) begin
            found = 1'b1;
            pos   = CW'(i);
          end else begin
            run = run + CW'(1);
          end
        end else begin
          free = 1'b1;
        end
      end
    end
    for (int i = 0; i < LW; i++) begin
      if (CW'(i) < pos) begin
        r[i] = c[i];
      end else if (CW'(i) == pos) begin
        r[i] = 1'b0;
      end else begin
        r[i] = ({1'b0, CW'(i)} <= ({1'b0, pos} + {1'b0, run} + (CW+1)'(1)));
      end
    end
    return {found, r};
  endfunction

  logic [MODE_W-1:0]    mode_bits;
  logic [SIZE_EN_W-1:0] size_enable;
  logic [LAYER_W-1:0]   layer_select;
  logic [LAYER_W-1:0]   required_layers;

  logic [LAYER_W-1:0]   hits;
  logic [LW-1:0]        comb;
  logic [CNT_W-1:0]     count;
  logic                 cut;
  logic                 pend_valid;
  logic [LAYER_W-1:0]   pend_mask;
  region_t              pend_region;
  region_t              out_region;

  logic [LW-1:0]        loc;
  logic [LAYER_W-1:0]   reg_mask;
  logic [LW-1:0]        dep;
  logic [LAYER_W-1:0]   enum_cand;
  logic [LAYER_W-1:0]   req;
  logic [LAYER_W-1:0]   sel;
  logic [LAYER_W-1:0]   got;
  logic [LAYER_W-1:0]   cand;
  logic                 cand_ok;
  logic [CW-1:0]        loc_count;
  logic [LW:0]          nxt;
  logic [LW-1:0]        first_comb;
  logic                 out_free;
  logic                 at_limit;
  logic                 take;
  logic                 stall;
  logic                 take_ok;
  logic                 move_push;
  logic                 move_flush;

  always_comb begin
    case (cmd.region)
      REG_BARREL: begin
        loc      = take_local(hits, 0, BARREL_LAYERS);
        reg_mask = span12(0, BARREL_LAYERS);
      end
      REG_NEG: begin
        loc      = take_local(hits, NEG_FIRST, ENDCAP_SIDE_LAYERS);
        reg_mask = span12(NEG_FIRST, ENDCAP_SIDE_LAYERS);
      end
      REG_POS: begin
        loc      = take_local(hits, POS_FIRST, ENDCAP_SIDE_LAYERS);
        reg_mask = span12(POS_FIRST, ENDCAP_SIDE_LAYERS);
      end
      default: begin
        loc      = '0;
        reg_mask = span12(0, ALL_END);
      end
    endcase
    dep = deposit(comb, loc);
    case (cmd.region)
      REG_BARREL: enum_cand = place(dep, 0, BARREL_LAYERS);
      REG_NEG:    enum_cand = place(dep, NEG_FIRST, ENDCAP_SIDE_LAYERS);
      REG_POS:    enum_cand = place(dep, POS_FIRST, ENDCAP_SIDE_LAYERS);
      default:    enum_cand = '0;
    endcase
  end

  assign req       = required_layers & reg_mask;
  assign sel       = layer_select & reg_mask;
  assign got       = sel & hits;
  assign loc_count = popcount(loc);
  assign nxt       = next_comb(comb, loc_count);

  always_comb begin
    if (!cmd.special) begin
      cand    = enum_cand;
      cand_ok = (enum_cand & req) == req;
    end else if (cmd.strict) begin
      cand    = sel;
      cand_ok = (sel != '0) && (got == sel);
    end else begin
      cand    = got;
      cand_ok = got != '0;
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < LW; i++) first_comb[i] = SIZE_W'(i) < cmd.size;
  end

  assign out_free   = !out_valid || out_ready;
  assign at_limit   = count == CNT_W'(RESULT_LIMIT);
  assign take       = cmd.step && cand_ok && !at_limit;
  assign stall      = take && pend_valid && !out_free;
  assign take_ok    = take && !stall;
  assign move_push  = take_ok && pend_valid;
  assign move_flush = cmd.flush && pend_valid && out_free;

  assign sts.mode         = mode_bits;
  assign sts.size_enable  = size_enable;
  assign sts.region_count = SIZE_W'(loc_count);
  assign sts.advance      = cmd.step && !stall;
  assign sts.hit_limit    = cand_ok && at_limit;
  assign sts.last_combo   = !nxt[LW];
  assign sts.flush_done   = !pend_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits       <= '0;
      size_enable     <= '0;
      layer_select    <= '0;
      required_layers <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:      mode_bits       <= cfg_data[MODE_W-1:0];
        CFG_SIZE_EN:   size_enable     <= cfg_data[SIZE_EN_W-1:0];
        CFG_LAYER_SEL: layer_select    <= cfg_data;
        CFG_REQUIRED:  required_layers <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      count      <= '0;
      cut        <= 1'b0;
    end else begin
      if (move_push || move_flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take_ok) begin
        pend_valid <= 1'b1;
      end else if (move_flush) begin
        pend_valid <= 1'b0;
      end
      if (cmd.load) begin
        count <= '0;
        cut   <= 1'b0;
      end else begin
        if (take_ok) count <= count + CNT_W'(1);
        if (cmd.step && cand_ok && at_limit) cut <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) hits <= hit_mask;
    if (cmd.init) begin
      comb <= first_comb;
    end else if (cmd.step && !cmd.special && !stall) begin
      comb <= nxt[LW-1:0];
    end
    if (take_ok) begin
      pend_mask   <= cand;
      pend_region <= cmd.region;
    end
    if (move_push) begin
      layer_mask  <= pend_mask;
      out_region  <= pend_region;
      truncated   <= 1'b0;
      last_result <= 1'b0;
    end else if (move_flush) begin
      layer_mask  <= pend_mask;
      out_region  <= pend_region;
      truncated   <= cut;
      last_result <= 1'b1;
    end
  end

  assign region = out_region;

endmodule

/* rtl/dlcs_ctrl.sv */
// ----------------------------------------------------------------------------
// dlcs_ctrl
// Event sequencer: picks the work for the mode, walks region and subset size
// jobs, steps the datapath and closes each event with a flush of the pending
// result.
// ----------------------------------------------------------------------------
module dlcs_ctrl #(
  parameter int unsigned BARREL_LAYERS      = 6,
  parameter int unsigned ENDCAP_SIDE_LAYERS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output dlcs_pkg::dlcs_cmd_t cmd,
  input  dlcs_pkg::dlcs_sts_t sts
);
  import dlcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_ENUM,
    S_SPEC,
    S_FLUSH
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] size_next;
  region_t           cur_region;
  region_t           region_next;

  logic              cosmic;
  logic              mix;
  logic              special;
  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W:0]   eidx;
  logic              job_en;
  logic              go;
  logic [SIZE_W-1:0] job_size;
  region_t           job_region;
  logic              jobs_done;

  assign cosmic  = sts.mode[MODE_COSMIC];
  assign mix     = sts.mode[MODE_MIX];
  assign special = sts.mode[MODE_SPECIAL];
  assign size_m1 = size - SIZE_W'(1);
  assign eidx    = (SIZE_W + 1)'(BARREL_LAYERS) + {1'b0, size} - (SIZE_W + 1)'(1);

  always_comb begin
    if (cur_region == REG_BARREL) begin
      job_en = (size_m1 < SIZE_W'(SIZE_EN_W)) && sts.size_enable[size_m1];
    end else begin
      job_en = (eidx < (SIZE_W + 1)'(SIZE_EN_W)) && sts.size_enable[eidx[SIZE_W-1:0]];
    end
  end

  assign go = job_en && (size <= sts.region_count);

  // job order: barrel sizes ascending, then per endcap size -z before +z
  always_comb begin
    job_size   = size;
    job_region = cur_region;
    jobs_done  = 1'b0;
    case (cur_region)
      REG_BARREL: begin
        if (size < SIZE_W'(BARREL_LAYERS)) begin
          job_size = size + SIZE_W'(1);
        end else begin
          job_size   = SIZE_W'(1);
          job_region = REG_NEG;
        end
      end
      REG_NEG: job_region = REG_POS;
      REG_POS: begin
        if (size < SIZE_W'(ENDCAP_SIDE_LAYERS)) begin
          job_size   = size + SIZE_W'(1);
          job_region = REG_NEG;
        end else begin
          jobs_done = 1'b1;
        end
      end
      default: jobs_done = 1'b1;
    endcase
  end

  always_comb begin
    state_next  = state;
    size_next   = size;
    region_next = cur_region;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          size_next   = SIZE_W'(1);
          region_next = REG_BARREL;
          if (!cosmic && !mix && !special) begin
            state_next = S_SETUP;
          end else if (!cosmic && !mix) begin
            state_next = S_SPEC;
          end else if (cosmic && special && !mix) begin
            state_next = S_SPEC;
          end else if (cosmic && special) begin
            state_next  = S_SPEC;
            region_next = REG_MIX;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_SETUP: begin
        if (go) begin
          state_next = S_ENUM;
        end else if (jobs_done) begin
          state_next = S_FLUSH;
        end else begin
          size_next   = job_size;
          region_next = job_region;
        end
      end
      S_ENUM: begin
        if (sts.advance) begin
          if (sts.hit_limit) begin
            state_next = S_FLUSH;
          end else if (sts.last_combo) begin
            if (jobs_done) begin
              state_next = S_FLUSH;
            end else begin
              state_next  = S_SETUP;
              size_next   = job_size;
              region_next = job_region;
            end
          end
        end
      end
      S_SPEC: begin
        if (sts.advance) begin
          if (sts.hit_limit || cur_region == REG_POS || cur_region == REG_MIX) begin
            state_next = S_FLUSH;
          end else begin
            region_next = region_t'(cur_region + 2'd1);
          end
        end
      end
      S_FLUSH: begin
        if (sts.flush_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      size       <= SIZE_W'(1);
      cur_region <= REG_BARREL;
    end else begin
      state      <= state_next;
      size       <= size_next;
      cur_region <= region_next;
    end
  end

  assign in_ready    = state == S_IDLE;
  assign cmd.load    = (state == S_IDLE) && in_valid;
  assign cmd.init    = (state == S_SETUP) && go;
  assign cmd.step    = (state == S_ENUM) || (state == S_SPEC);
  assign cmd.flush   = state == S_FLUSH;
  assign cmd.special = state == S_SPEC;
  assign cmd.strict  = !cosmic;
  assign cmd.region  = cur_region;
  assign cmd.size    = size;

endmodule

/* rtl/detector_layer_combination_selector_top.sv */
// ----------------------------------------------------------------------------
// detector_layer_combination_selector_top
// Turns one event's hit layer mask into the selected layer combinations.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       hit_mask
//   out      output     out_valid / out_ready     layer_mask, region,
//                                                 truncated, last_result
//   cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one event at a time: the sequencer takes the event, sets up each subset
// size job, steps through the candidate combinations in the stepper and
// ends with the closing flush; results leave at most one per cycle
// the combination stepper sets the rate: one candidate, kept or dropped,
// per cycle while the stepper is not stalled
// a full output register with out_ready low stalls the stepper only when a
// new result has to pass the one-deep pending stage
// rst is synchronous and clears the registers, the sequencer and all valids
// ----------------------------------------------------------------------------
module detector_layer_combination_selector_top #(
  parameter int unsigned BARREL_LAYERS      = 6,
  parameter int unsigned ENDCAP_SIDE_LAYERS = 3,
  parameter int unsigned RESULT_LIMIT       = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dlcs_pkg::LAYER_W-1:0]    hit_mask,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dlcs_pkg::LAYER_W-1:0]    layer_mask,
  output logic [1:0]                      region,
  output logic                            truncated,
  output logic                            last_result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlcs_pkg::LAYER_W-1:0]    cfg_data
);
  import dlcs_pkg::*;

  dlcs_cmd_t cmd;
  dlcs_sts_t sts;

  assign cfg_ready = 1'b1;

  dlcs_ctrl #(
    .BARREL_LAYERS      (BARREL_LAYERS),
    .ENDCAP_SIDE_LAYERS (ENDCAP_SIDE_LAYERS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dlcs_datapath #(
    .BARREL_LAYERS      (BARREL_LAYERS),
    .ENDCAP_SIDE_LAYERS (ENDCAP_SIDE_LAYERS),
    .RESULT_LIMIT       (RESULT_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .hit_mask    (hit_mask),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .layer_mask  (layer_mask),
    .region      (region),
    .truncated   (truncated),
    .last_result (last_result)
  );

endmodule

/* rtl/dlcs_checker.sv */
// ----------------------------------------------------------------------------
// dlcs_checker
// Port-level checks of the selector: output hold under stall, flag pairing,
// mixed-region results, the busy phase after each input transfer and a quiet output after reset.
// ----------------------------------------------------------------------------
module dlcs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dlcs_pkg::LAYER_W-1:0]    layer_mask,
  input logic [1:0]                      region,
  input logic                            truncated,
  input logic                            last_result
);
  import dlcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(layer_mask) && $stable(region)
      && $stable(last_result) && $stable(truncated))
    else $error("output changed while stalled");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> last_result)
    else $error("truncated flag without last result");

  a_mix_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == REG_MIX |-> last_result)
    else $error("mixed region result not alone");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind detector_layer_combination_selector_top dlcs_checker u_dlcs_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the detector layer combination selector. Events are
// driven through the input channel, a scoreboard works out the expected
// layer combinations for each accepted hit mask from its own copy of the
// registers, and every output transfer is checked in order. Directed events
// cover each mode and the truncation limit. Random phases then follow, with
// random register settings and mostly well-formed hit masks, under changing
// backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import dlcs_pkg::*;

  localparam int BARREL_LAYERS      = 6;
  localparam int ENDCAP_SIDE_LAYERS = 3;
  localparam int RESULT_LIMIT       = 64;
  localparam int NEG_START          = BARREL_LAYERS;
  localparam int POS_START          = BARREL_LAYERS + ENDCAP_SIDE_LAYERS;
  localparam int ALL_LAYERS         = BARREL_LAYERS + 2 * ENDCAP_SIDE_LAYERS;
  localparam int DRAIN_CYCLES       = 128;
  localparam int HOLD_CYCLES        = 400;
  localparam int PHASES             = 10;
  localparam int PHASE_ITEMS        = 40;
  localparam int TIMEOUT_TIME       = 5_000_000;

  localparam logic [MODE_W-1:0] MODE_ALL_SIZES      = '0;
  localparam logic [MODE_W-1:0] MODE_FIXED          = MODE_W'(1 << MODE_SPECIAL);
  localparam logic [MODE_W-1:0] MODE_COSMIC_SPECIAL =
    MODE_W'((1 << MODE_SPECIAL) | (1 << MODE_COSMIC));
  localparam logic [MODE_W-1:0] MODE_COSMIC_MIXED   =
    MODE_W'((1 << MODE_SPECIAL) | (1 << MODE_COSMIC) | (1 << MODE_MIX));
  localparam logic [MODE_W-1:0] MODE_MIX_ONLY       = MODE_W'(1 << MODE_MIX);
  localparam logic [MODE_W-1:0] MODE_COSMIC_ONLY    = MODE_W'(1 << MODE_COSMIC);
  localparam logic [MODE_W-1:0] MODE_COSMIC_MIX     =
    MODE_W'((1 << MODE_COSMIC) | (1 << MODE_MIX));
  localparam logic [MODE_W-1:0] MODE_SPECIAL_MIX    =
    MODE_W'((1 << MODE_SPECIAL) | (1 << MODE_MIX));

  typedef logic [LAYER_W-1:0] lmask_t;

  typedef struct packed {
    lmask_t  mask;
    region_t rg;
    logic    trunc;
    logic    is_last;
  } combo_t;

  class combo_scoreboard;
    logic [MODE_W-1:0]    mode;
    logic [SIZE_EN_W-1:0] size_en;
    lmask_t               layer_sel;
    lmask_t               required;
    combo_t               expected_combos[$];
    combo_t               scratch[$];
    lmask_t               hits_now;
    bit                   cut;
    int                   events;
    int                   checked;
    int                   cut_events;
    int                   errors;

    function new();
      mode       = '0;
      size_en    = '0;
      layer_sel  = '0;
      required   = '0;
      events     = 0;
      checked    = 0;
      cut_events = 0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, lmask_t data);
      case (idx)
        CFG_MODE: begin
          mode = data[MODE_W-1:0];
        end
        CFG_SIZE_EN: begin
          size_en = data[SIZE_EN_W-1:0];
        end
        CFG_LAYER_SEL: begin
          layer_sel = data;
        end
        CFG_REQUIRED: begin
          required = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int outstanding();
      return expected_combos.size();
    endfunction

    function lmask_t span(int first, int count);
      return lmask_t'(((1 << count) - 1) << first);
    endfunction

    function void put(lmask_t m, region_t rg);
      combo_t c;
      if (scratch.size() >= RESULT_LIMIT) begin
        cut = 1'b1;
        return;
      end
      c.mask    = m;
      c.rg      = rg;
      c.trunc   = 1'b0;
      c.is_last = 1'b0;
      scratch = {scratch, c};
    endfunction

    // subsets of one size over the hit layers of a region, lexicographic order
    function void enumerate(int first, int count, int size, region_t rg);
      int     lay[$];
      int     idx[8];
      int     i;
      int     j;
      int     m;
      bit     more;
      lmask_t req;
      lmask_t cand;
      if (cut) return;
      req = required & span(first, count);
      for (i = first; i < first + count; i++) begin
        if (hits_now[i]) lay = {lay, i};
      end
      m = lay.size();
      if (size > m) return;
      for (i = 0; i < size; i++) idx[i] = i;
      more = 1'b1;
      while (more && !cut) begin
        cand = '0;
        for (i = 0; i < size; i++) cand[lay[idx[i]]] = 1'b1;
        if ((cand & req) == req) put(cand, rg);
        i = size - 1;
        while (i >= 0 && idx[i] == m - size + i) i--;
        if (i < 0) begin
          more = 1'b0;
        end else begin
          idx[i]++;
          for (j = i + 1; j < size; j++) idx[j] = idx[j-1] + 1;
        end
      end
    endfunction

    function void pick_special(lmask_t region_span, region_t rg, bit need_all);
      lmask_t sel;
      lmask_t got;
      sel = layer_sel & region_span;
      got = sel & hits_now;
      if (need_all) begin
        if (sel != '0 && got == sel) put(sel, rg);
      end else if (got != '0) begin
        put(got, rg);
      end
    endfunction

    function void note_event(lmask_t hits);
      bit cosmic;
      bit mix;
      bit special;
      int s;
      int b;
      int n;
      scratch.delete();
      cut      = 1'b0;
      hits_now = hits;
      events++;
      cosmic  = mode[MODE_COSMIC];
      mix     = mode[MODE_MIX];
      special = mode[MODE_SPECIAL];
      if (!cosmic) begin
        if (!mix && !special) begin
          for (s = 1; s <= BARREL_LAYERS; s++) begin
            if (size_en[s-1]) enumerate(0, BARREL_LAYERS, s, REG_BARREL);
          end
          for (s = 1; s <= ENDCAP_SIDE_LAYERS; s++) begin
            b = BARREL_LAYERS + s - 1;
            if (b < SIZE_EN_W && size_en[b]) begin
              enumerate(NEG_START, ENDCAP_SIDE_LAYERS, s, REG_NEG);
              enumerate(POS_START, ENDCAP_SIDE_LAYERS, s, REG_POS);
            end
          end
        end else if (!mix) begin
          pick_special(span(0, BARREL_LAYERS), REG_BARREL, 1'b1);
          pick_special(span(NEG_START, ENDCAP_SIDE_LAYERS), REG_NEG, 1'b1);
          pick_special(span(POS_START, ENDCAP_SIDE_LAYERS), REG_POS, 1'b1);
        end
      end else if (special) begin
        if (!mix) begin
          pick_special(span(0, BARREL_LAYERS), REG_BARREL, 1'b0);
          pick_special(span(NEG_START, ENDCAP_SIDE_LAYERS), REG_NEG, 1'b0);
          pick_special(span(POS_START, ENDCAP_SIDE_LAYERS), REG_POS, 1'b0);
        end else begin
          pick_special(span(0, ALL_LAYERS), REG_MIX, 1'b0);
        end
      end
      n = scratch.size();
      if (n > 0) begin
        scratch[n-1].is_last = 1'b1;
        scratch[n-1].trunc   = cut;
        if (cut) cut_events++;
      end
      foreach (scratch[i]) expected_combos = {expected_combos, scratch[i]};
    endfunction

    task report(string msg);
      errors++;
      $display("tb_top: mismatch: %s", msg);
    endtask

    task check_combo(lmask_t m, logic [1:0] rg, logic trunc, logic is_last);
      combo_t want;
      if (expected_combos.size() == 0) begin
        report($sformatf("unexpected result layer_mask %h region %0d", m, rg));
        return;
      end
      want = expected_combos.pop_front();
      checked++;
      if (m !== want.mask)
        report($sformatf("result %0d layer_mask %h, want %h", checked, m, want.mask));
      if (rg !== want.rg)
        report($sformatf("result %0d region %0d, want %0d", checked, rg, want.rg));
      if (trunc !== want.trunc)
        report($sformatf("result %0d truncated %b, want %b", checked, trunc, want.trunc));
      if (is_last !== want.is_last)
        report($sformatf("result %0d last_result %b, want %b", checked, is_last,
                         want.is_last));
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid;
  logic           in_ready;
  lmask_t         hit_mask;
  logic           out_valid;
  logic           out_ready;
  lmask_t         layer_mask;
  logic [1:0]     region;
  logic           truncated;
  logic           last_result;
  logic           cfg_valid;
  logic           cfg_ready;
  cfg_idx_t       cfg_index;
  lmask_t         cfg_data;

  combo_scoreboard sb;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              hold_request;
  int              cfg_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  detector_layer_combination_selector_top #(
    .BARREL_LAYERS      (BARREL_LAYERS),
    .ENDCAP_SIDE_LAYERS (ENDCAP_SIDE_LAYERS),
    .RESULT_LIMIT       (RESULT_LIMIT)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .hit_mask    (hit_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .layer_mask  (layer_mask),
    .region      (region),
    .truncated   (truncated),
    .last_result (last_result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  task send_event(lmask_t hits);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    hit_mask <= hits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(hits);
  endtask

  task pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task drive_reg(cfg_idx_t idx, lmask_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  // registers change only with the block idle; dirty puts noise above the mode and size enable widths
  task load_config(logic [MODE_W-1:0] m, logic [SIZE_EN_W-1:0] s, lmask_t sel,
                   lmask_t req, bit dirty);
    lmask_t data;
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    data = dirty ? lmask_t'($urandom_range(4095)) : '0;
    data[MODE_W-1:0] = m;
    drive_reg(CFG_MODE, data);
    data = dirty ? lmask_t'($urandom_range(4095)) : '0;
    data[SIZE_EN_W-1:0] = s;
    drive_reg(CFG_SIZE_EN, data);
    drive_reg(CFG_LAYER_SEL, sel);
    drive_reg(CFG_REQUIRED, req);
    cfg_valid <= 1'b0;
  endtask

  // output side: check every transfer, then pick out_ready for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_combo(layer_mask, region, truncated, last_result);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int                   p;
    int                   k;
    logic [MODE_W-1:0]    pmode;
    logic [SIZE_EN_W-1:0] psize;
    lmask_t               psel;
    lmask_t               preq;
    lmask_t               hits;
    sb           = new();
    in_valid     = 1'b0;
    hit_mask     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MODE;
    cfg_data     = '0;
    hold_request = 0;
    cfg_writes   = 0;
    tx_idle_pct  = 9;
    rx_idle_pct  = 55;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed events
    load_config(MODE_ALL_SIZES, '0, '0, '0, 1'b0);
    send_event(12'hFFF);
    load_config(MODE_ALL_SIZES, 9'h1FF, 12'hFFF, '0, 1'b0);
    send_event(12'hFFF);
    send_event(12'h000);
    send_event(12'h001);
    send_event(12'h800);
    send_event(12'h1C0);
    load_config(MODE_ALL_SIZES, 9'h1FF, '0, 12'hFFF, 1'b0);
    send_event(12'hFFF);
    send_event(12'h03F);
    load_config(MODE_FIXED, '0, 12'hFFF, '0, 1'b0);
    send_event(12'hFFF);
    send_event(12'hFFE);
    send_event(12'h000);
    load_config(MODE_FIXED, 9'h1FF, '0, 12'hFFF, 1'b0);
    send_event(12'hFFF);
    load_config(MODE_COSMIC_SPECIAL, '0, 12'hAAA, '0, 1'b0);
    send_event(12'h555);
    send_event(12'hFFF);
    send_event(12'hA0A);
    load_config(MODE_COSMIC_MIXED, '0, 12'hFFF, '0, 1'b0);
    send_event(12'h001);
    send_event(12'h000);
    load_config(MODE_MIX_ONLY, 9'h1FF, 12'hFFF, '0, 1'b0);
    send_event(12'hFFF);
    load_config(MODE_COSMIC_MIX, 9'h1FF, 12'hFFF, '0, 1'b0);
    send_event(12'hFFF);
    load_config(MODE_COSMIC_ONLY, 9'h1FF, 12'hFFF, '0, 1'b0);
    send_event(12'hFFF);
    load_config(MODE_SPECIAL_MIX, 9'h1FF, 12'hFFF, '0, 1'b0);
    send_event(12'hFFF);

    // long output stall while full events keep coming
    load_config(MODE_ALL_SIZES, 9'h1FF, '0, '0, 1'b0);
    tx_idle_pct  = 0;
    hold_request = HOLD_CYCLES;
    repeat (6) send_event(12'hFFF);

    for (p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 9;
        rx_idle_pct = 55;
      end else if (p < 8) begin
        tx_idle_pct = 55;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(11))
        0, 1, 2, 3, 4, 5: pmode = MODE_ALL_SIZES;
        6, 7: pmode = MODE_FIXED;
        8: pmode = MODE_COSMIC_SPECIAL;
        9: pmode = MODE_COSMIC_MIXED;
        10: pmode = MODE_MIX_ONLY;
        default: pmode = MODE_COSMIC_ONLY;
      endcase
      psize = ($urandom_range(3) == 0) ? 9'h1FF : SIZE_EN_W'($urandom_range(511));
      psel  = lmask_t'($urandom_range(4095));
      preq  = ($urandom_range(2) == 0) ? '0 :
              lmask_t'($urandom_range(4095) & $urandom_range(4095) & $urandom_range(4095));
      load_config(pmode, psize, psel, preq, 1'b1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(7))
          0: hits = 12'hFFF;
          1: hits = lmask_t'($urandom_range(4095) & $urandom_range(4095));
          2, 3: hits = lmask_t'($urandom_range(4095));
          default: hits = lmask_t'($urandom_range(4095)) | preq | psel;
        endcase
        if (k == PHASE_ITEMS / 2) pause_until_drained();
        send_event(hits);
      end
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d events, %0d register writes, %0d combinations checked",
             sb.events, cfg_writes, sb.checked);
    $display("tb_top: %0d events hit the result limit; %s", sb.cut_events,
             "all-sizes, fixed, cosmic, mixed and idle modes run");
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
